@@ rtl/pmp_chk_pkg.sv @@
// Shared types and constants for the physical memory protection checker.
package pmp_chk_pkg;

    typedef enum logic
    {
        OP_CSR_WRITE    = 1'b0,
        OP_ACCESS_CHECK = 1'b1
    } pmp_opcode_t;

    typedef enum logic [1:0]
    {
        MODE_OFF   = 2'd0,
        MODE_TOR   = 2'd1,
        MODE_NA4   = 2'd2,
        MODE_NAPOT = 2'd3
    } pmp_mode_t;

    // Bit positions inside one configuration byte.
    localparam int CFG_R    = 0;
    localparam int CFG_W    = 1;
    localparam int CFG_X    = 2;
    localparam int CFG_A_LO = 3;
    localparam int CFG_A_HI = 4;
    localparam int CFG_L    = 7;

    // Bits 6:5 of a configuration byte always read back as zero.
    localparam logic [7:0] CFG_WRITE_MASK = 8'h9f;

    // 0x3a0-0x3a3 hold the packed configuration bytes, 0x3b0 onward the addresses.
    localparam logic [9:0] CFG_CSR_PREFIX  = 10'h0e8;
    localparam logic [7:0] ADDR_CSR_PREFIX = 8'h3b;

    localparam logic [1:0] PRIV_MACHINE = 2'd3;

    typedef struct packed
    {
        pmp_opcode_t opcode;
        logic [11:0] csr_number;
        logic [31:0] write_value;
        logic [31:0] access_addr;
        logic [3:0]  access_size;
        logic [1:0]  privilege;
        logic        want_read;
        logic        want_write;
        logic        want_exec;
    } pmp_req_t;

    typedef struct packed
    {
        logic        csr_claimed;
        logic        access_fault;
        logic [31:0] fault_address;
    } pmp_rsp_t;

endpackage

@@ rtl/pmp_chk_match.sv @@
// First-match lookup of one byte address against all protection entries.
module pmp_chk_match
    import pmp_chk_pkg::*;
#(
    parameter int ENTRY_COUNT   = 16,
    parameter int ADDRESS_WIDTH = 32
)
(
    input  logic [ENTRY_COUNT-1:0][7:0]               entry_cfg,
    input  logic [ENTRY_COUNT-1:0][ADDRESS_WIDTH-1:0] entry_addr,
    input  logic [ADDRESS_WIDTH-1:0]                  byte_addr,
    output logic                                      hit,
    output logic [7:0]                                hit_cfg
);

    logic [ADDRESS_WIDTH-1:0] word_addr;
    logic [ENTRY_COUNT-1:0]   entry_hit;

    assign word_addr = byte_addr >> 2;

    for (genvar i = 0; i < ENTRY_COUNT; i++)
    begin : g_entry
        logic [ADDRESS_WIDTH-1:0] lower;
        logic [ADDRESS_WIDTH-1:0] napot_mask;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_rest
            assign lower = entry_addr[i-1];
        end

        // The trailing ones of the address and the zero above them mark the
        // bits that the region ignores.
        assign napot_mask = entry_addr[i] ^ (entry_addr[i] + ADDRESS_WIDTH'(1));

        always_comb
        begin
            unique case (pmp_mode_t'(entry_cfg[i][CFG_A_HI:CFG_A_LO]))
                MODE_OFF:   entry_hit[i] = 1'b0;
                MODE_TOR:   entry_hit[i] = (word_addr >= lower) && (word_addr < entry_addr[i]);
                MODE_NA4:   entry_hit[i] = (word_addr == entry_addr[i]);
                MODE_NAPOT: entry_hit[i] = (((word_addr ^ entry_addr[i]) & ~napot_mask) == '0);
                default:    entry_hit[i] = 1'b0;
            endcase
        end
    end

    // Lowest numbered matching entry wins.
    always_comb
    begin
        hit     = 1'b0;
        hit_cfg = '0;
        for (int i = ENTRY_COUNT - 1; i >= 0; i--)
        begin
            if (entry_hit[i])
            begin
                hit     = 1'b1;
                hit_cfg = entry_cfg[i];
            end
        end
    end

endmodule

@@ rtl/pmp_chk_regs.sv @@
// Configuration and address registers with lock handling for CSR writes.
module pmp_chk_regs
    import pmp_chk_pkg::*;
#(
    parameter int ENTRY_COUNT   = 16,
    parameter int ADDRESS_WIDTH = 32
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      write_en,
    input  logic [11:0]                               csr_number,
    input  logic [31:0]                               write_value,
    output logic                                      claimed,
    output logic [ENTRY_COUNT-1:0][7:0]               entry_cfg,
    output logic [ENTRY_COUNT-1:0][ADDRESS_WIDTH-1:0] entry_addr,
    output logic                                      any_enabled
);

    localparam logic [4:0] ENTRY_LIMIT = 5'(ENTRY_COUNT);

    logic [ENTRY_COUNT-1:0][7:0]               cfg_reg;
    logic [ENTRY_COUNT-1:0][7:0]               cfg_next;
    logic [ENTRY_COUNT-1:0][ADDRESS_WIDTH-1:0] addr_reg;
    logic [ENTRY_COUNT-1:0][ADDRESS_WIDTH-1:0] addr_next;
    logic                                      any_en_reg;
    logic                                      any_en_next;
    logic                                      cfg_hit;
    logic                                      addr_hit;
    logic [ENTRY_COUNT-1:0]                    addr_locked;

    assign cfg_hit  = (csr_number[11:2] == CFG_CSR_PREFIX);
    assign addr_hit = (csr_number[11:4] == ADDR_CSR_PREFIX)
                   && ({1'b0, csr_number[3:0]} < ENTRY_LIMIT);
    assign claimed  = cfg_hit || addr_hit;

    // An address is frozen by its own lock, or by a locked TOR entry above it
    // that uses it as the lower bound.
    for (genvar i = 0; i < ENTRY_COUNT; i++)
    begin : g_lock
        if (i < ENTRY_COUNT - 1)
        begin : g_inner
            assign addr_locked[i] = cfg_reg[i][CFG_L]
                || (cfg_reg[i+1][CFG_L]
                    && (pmp_mode_t'(cfg_reg[i+1][CFG_A_HI:CFG_A_LO]) == MODE_TOR));
        end
        else
        begin : g_last
            assign addr_locked[i] = cfg_reg[i][CFG_L];
        end
    end

    always_comb
    begin
        any_en_next = 1'b0;
        for (int i = 0; i < ENTRY_COUNT; i++)
        begin
            cfg_next[i]  = cfg_reg[i];
            addr_next[i] = addr_reg[i];
            if (write_en && cfg_hit && (csr_number[1:0] == 2'(i >> 2)) && !cfg_reg[i][CFG_L])
            begin
                cfg_next[i] = write_value[8*(i%4) +: 8] & CFG_WRITE_MASK;
            end
            if (write_en && addr_hit && (csr_number[3:0] == 4'(i)) && !addr_locked[i])
            begin
                addr_next[i] = ADDRESS_WIDTH'(write_value);
            end
            if (pmp_mode_t'(cfg_next[i][CFG_A_HI:CFG_A_LO]) != MODE_OFF)
            begin
                any_en_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= '0;
            addr_reg   <= '0;
            any_en_reg <= 1'b0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            addr_reg   <= addr_next;
            any_en_reg <= any_en_next;
        end
    end

    assign entry_cfg   = cfg_reg;
    assign entry_addr  = addr_reg;
    assign any_enabled = any_en_reg;

endmodule

@@ rtl/pmp_chk_eval.sv @@
// Access check: looks up the first and last byte and applies the permissions.
module pmp_chk_eval
    import pmp_chk_pkg::*;
#(
    parameter int ENTRY_COUNT   = 16,
    parameter int ADDRESS_WIDTH = 32
)
(
    input  pmp_req_t                                  req,
    input  logic [ENTRY_COUNT-1:0][7:0]               entry_cfg,
    input  logic [ENTRY_COUNT-1:0][ADDRESS_WIDTH-1:0] entry_addr,
    input  logic                                      any_enabled,
    output logic                                      fault,
    output logic [ADDRESS_WIDTH-1:0]                  fault_addr
);

    logic                     is_machine;
    logic [3:0]               size;
    logic [3:0]               size_m1;
    logic [ADDRESS_WIDTH-1:0] lo_addr;
    logic [ADDRESS_WIDTH-1:0] hi_addr;
    logic [ADDRESS_WIDTH-1:0] hi_fail;
    logic                     lo_hit;
    logic                     hi_hit;
    logic [7:0]               lo_cfg;
    logic [7:0]               hi_cfg;
    logic                     lo_bad;
    logic                     hi_bad;

    assign is_machine = (req.privilege == PRIV_MACHINE);
    assign size       = (req.access_size == 4'd0) ? 4'd1 : req.access_size;
    assign size_m1    = size - 4'd1;
    assign lo_addr    = ADDRESS_WIDTH'(req.access_addr);
    assign hi_addr    = lo_addr + ADDRESS_WIDTH'(size_m1);
    assign hi_fail    = hi_addr & ~ADDRESS_WIDTH'(size_m1);

    pmp_chk_match #(
        .ENTRY_COUNT  (ENTRY_COUNT),
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_lo_match (
        .entry_cfg (entry_cfg),
        .entry_addr(entry_addr),
        .byte_addr (lo_addr),
        .hit       (lo_hit),
        .hit_cfg   (lo_cfg)
    );

    pmp_chk_match #(
        .ENTRY_COUNT  (ENTRY_COUNT),
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_hi_match (
        .entry_cfg (entry_cfg),
        .entry_addr(entry_addr),
        .byte_addr (hi_addr),
        .hit       (hi_hit),
        .hit_cfg   (hi_cfg)
    );

    // A byte with no match faults outside machine mode. Machine mode skips the
    // permissions of unlocked entries.
    function automatic logic byte_bad(input logic hit, input logic [7:0] cfg,
                                      input logic is_m, input logic rd,
                                      input logic wr, input logic ex);
        logic viol;
        viol = (rd && !cfg[CFG_R]) || (wr && !cfg[CFG_W]) || (ex && !cfg[CFG_X]);
        if (!hit)
        begin
            return !is_m;
        end
        return !(is_m && !cfg[CFG_L]) && viol;
    endfunction

    assign lo_bad = byte_bad(lo_hit, lo_cfg, is_machine, req.want_read,
                             req.want_write, req.want_exec);
    assign hi_bad = byte_bad(hi_hit, hi_cfg, is_machine, req.want_read,
                             req.want_write, req.want_exec);

    always_comb
    begin
        if (!any_enabled)
        begin
            fault      = !is_machine;
            fault_addr = lo_addr;
        end
        else
        begin
            fault      = lo_bad || hi_bad;
            fault_addr = lo_bad ? lo_addr : hi_fail;
        end
    end

endmodule

@@ rtl/physical_memory_protection_check.sv @@
// Top level of the physical memory protection checker.
//
// Each request beat is either a CSR write to the PMP configuration and
// address registers or an access check of one load, store or fetch. A beat
// is taken into an input register and its response beat is captured in the
// output register once that is free; one beat is accepted every cycle while
// rsp_stall does not hold back a valid response. The rate is set by the single
// combinational pass that matches both the first and the last byte against
// every entry in parallel. A CSR write takes effect for the very next beat.
// fault_address always shows the address recorded by the most recent fault.
module physical_memory_protection_check
    import pmp_chk_pkg::*;
#(
    parameter int ENTRY_COUNT   = 16,
    parameter int ADDRESS_WIDTH = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  pmp_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output pmp_rsp_t rsp
);

    pmp_req_t                                  req_reg;
    logic                                      req_valid_reg;
    logic                                      req_valid_next;
    pmp_rsp_t                                  rsp_reg;
    pmp_rsp_t                                  rsp_next;
    logic                                      rsp_valid_reg;
    logic                                      rsp_valid_next;
    logic [ADDRESS_WIDTH-1:0]                  fault_addr_reg;
    logic [ADDRESS_WIDTH-1:0]                  fault_addr_next;
    logic                                      out_free;
    logic                                      fire;
    logic                                      accept;
    logic                                      is_write;
    logic                                      claimed;
    logic                                      fault;
    logic [ADDRESS_WIDTH-1:0]                  fault_addr;
    logic [ENTRY_COUNT-1:0][7:0]               entry_cfg;
    logic [ENTRY_COUNT-1:0][ADDRESS_WIDTH-1:0] entry_addr;
    logic                                      any_enabled;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign fire      = req_valid_reg && out_free;
    assign req_stall = req_valid_reg && !out_free;
    assign accept    = req_valid && !req_stall;
    assign is_write  = (req_reg.opcode == OP_CSR_WRITE);

    pmp_chk_regs #(
        .ENTRY_COUNT  (ENTRY_COUNT),
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .write_en   (fire && is_write),
        .csr_number (req_reg.csr_number),
        .write_value(req_reg.write_value),
        .claimed    (claimed),
        .entry_cfg  (entry_cfg),
        .entry_addr (entry_addr),
        .any_enabled(any_enabled)
    );

    pmp_chk_eval #(
        .ENTRY_COUNT  (ENTRY_COUNT),
        .ADDRESS_WIDTH(ADDRESS_WIDTH)
    ) u_eval (
        .req        (req_reg),
        .entry_cfg  (entry_cfg),
        .entry_addr (entry_addr),
        .any_enabled(any_enabled),
        .fault      (fault),
        .fault_addr (fault_addr)
    );

    always_comb
    begin
        fault_addr_next = fault_addr_reg;
        if (fire && !is_write && fault)
        begin
            fault_addr_next = fault_addr;
        end

        rsp_next.csr_claimed   = is_write && claimed;
        rsp_next.access_fault  = !is_write && fault;
        rsp_next.fault_address = fault_addr_next[31:0];

        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (fire)
        begin
            req_valid_next = 1'b0;
        end
        else
        begin
            req_valid_next = req_valid_reg;
        end

        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            fault_addr_reg <= '0;
        end
        else
        begin
            req_valid_reg  <= req_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            fault_addr_reg <= fault_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
